@@ design/nclab_pkg.sv @@
// Shared types, sizes and helpers for the nearest centroid labeler.
// Used by nclab_cell and nearest_centroid_labeler_top; depends on nothing else.
package nclab_pkg;

   // Table size and field widths.
   localparam int MAX_CENTROIDS = 64;
   localparam int COORD_BITS    = 12;
   localparam int LABEL_BITS    = 8;
   localparam int INDEX_BITS    = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int COUNT_BITS    = 7;
   localparam int EFF_BITS      = INDEX_BITS + 1;
   localparam int DIST_BITS     = 2 * COORD_BITS + 1;

   // Stream payload sizes.
   localparam int REQ_FIELD_BITS = 2 * COORD_BITS + INDEX_BITS + LABEL_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = LABEL_BITS + INDEX_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Register port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_CENTROID_COUNT = 3'd0;

   // Item kinds carried in the request tuser bit.
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // One query moving down the chain: the pixel, the best match so far and
   // the distance that the previous cell computed but has not yet compared.
   typedef struct packed {
      logic                  valid;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  best_valid;
      logic [DIST_BITS-1:0]  best_dist;
      logic [INDEX_BITS-1:0] best_index;
      logic [LABEL_BITS-1:0] best_label;
      logic                  pend_valid;
      logic [DIST_BITS-1:0]  pend_dist;
      logic [INDEX_BITS-1:0] pend_index;
      logic [LABEL_BITS-1:0] pend_label;
   } token_type;

   // Fold the pending distance into the best match. A strict compare keeps
   // the lower index on a tie, since entries arrive in ascending order.
   function automatic token_type merge_pend(input token_type tok);
      token_type res;
      logic      take;
      res  = tok;
      take = tok.pend_valid && (!tok.best_valid || (tok.pend_dist < tok.best_dist));
      if (take) begin
         res.best_dist  = tok.pend_dist;
         res.best_index = tok.pend_index;
         res.best_label = tok.pend_label;
      end
      res.best_valid = tok.best_valid | tok.pend_valid;
      res.pend_valid = 1'b0;
      return res;
   endfunction

   // Absolute difference of two coordinates.
   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ design/nclab_cell.sv @@
// One cell of the centroid chain: holds one table entry and advances a query
// token by one step per cycle. Depends on nclab_pkg.
module nclab_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [nclab_pkg::INDEX_BITS-1:0] cell_index,
   input  logic [nclab_pkg::EFF_BITS-1:0]   active_count,
   input  logic                            wr_en,
   input  logic [nclab_pkg::COORD_BITS-1:0] wr_x,
   input  logic [nclab_pkg::COORD_BITS-1:0] wr_y,
   input  logic [nclab_pkg::LABEL_BITS-1:0] wr_label,
   input  nclab_pkg::token_type            tok_in,
   output nclab_pkg::token_type            tok_out
);

   logic [nclab_pkg::COORD_BITS-1:0]   cent_x_ff;
   logic [nclab_pkg::COORD_BITS-1:0]   cent_y_ff;
   logic [nclab_pkg::LABEL_BITS-1:0]   label_ff;
   nclab_pkg::token_type               tok_ff;
   nclab_pkg::token_type               tok_in_merged;
   nclab_pkg::token_type               tok_in_next;
   logic [nclab_pkg::COORD_BITS-1:0]   dx;
   logic [nclab_pkg::COORD_BITS-1:0]   dy;
   logic [2*nclab_pkg::COORD_BITS-1:0] sq_x;
   logic [2*nclab_pkg::COORD_BITS-1:0] sq_y;
   logic                               active;

   // Entry storage, written by load beats addressed to this cell.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cent_x_ff <= wr_x;
         cent_y_ff <= wr_y;
         label_ff  <= wr_label;
      end
   end

   // Compare the distance handed over by the previous cell, and compute the
   // squared distance of this cell's entry for the next cell to compare.
   always_comb begin
      tok_in_merged = nclab_pkg::merge_pend(tok_in);
      dx            = nclab_pkg::abs_diff(tok_in.x, cent_x_ff);
      dy            = nclab_pkg::abs_diff(tok_in.y, cent_y_ff);
      sq_x          = (2*nclab_pkg::COORD_BITS)'(dx) * (2*nclab_pkg::COORD_BITS)'(dx);
      sq_y          = (2*nclab_pkg::COORD_BITS)'(dy) * (2*nclab_pkg::COORD_BITS)'(dy);
      active        = {1'b0, cell_index} < active_count;

      tok_in_next            = tok_in_merged;
      tok_in_next.pend_valid = active;
      tok_in_next.pend_dist  = nclab_pkg::DIST_BITS'(sq_x) + nclab_pkg::DIST_BITS'(sq_y);
      tok_in_next.pend_index = cell_index;
      tok_in_next.pend_label = label_ff;
   end

   // Token register toward the next cell; only the valid bit needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.x          <= tok_in_next.x;
      tok_ff.y          <= tok_in_next.y;
      tok_ff.best_valid <= tok_in_next.best_valid;
      tok_ff.best_dist  <= tok_in_next.best_dist;
      tok_ff.best_index <= tok_in_next.best_index;
      tok_ff.best_label <= tok_in_next.best_label;
      tok_ff.pend_valid <= tok_in_next.pend_valid;
      tok_ff.pend_dist  <= tok_in_next.pend_dist;
      tok_ff.pend_index <= tok_in_next.pend_index;
      tok_ff.pend_label <= tok_in_next.pend_label;
   end

   assign tok_out = tok_ff;

endmodule

@@ design/nearest_centroid_labeler_top.sv @@
// Top level of the nearest centroid labeler: stream ports, register port and
// the chain of nclab_cell instances. Depends on nclab_pkg and nclab_cell.
//
// The block stores up to 64 centroids, one per cell of a chain, each with
// its 2-D coordinate and an 8-bit label. A load beat (tuser op = 0) writes
// one entry. A query beat (tuser op = 1) enters the chain and moves one
// cell per cycle; each cell computes the exact squared distance of its
// entry, and the next cell, or the final compare after the last cell, folds
// it into the running best. The answer then passes through the done stage
// to the output register. The chain holds one query at a time: a new beat
// of either kind is accepted once the previous result has moved from the
// done stage into the output register, even while its response still waits
// there. Only entries below centroid_count take part (a count of zero acts
// as one, counts above 64 act as 64); on equal distances the lowest index
// wins. Querying an entry that was never loaded gives an undefined answer.
module nearest_centroid_labeler_top (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: coord_x, coord_y, entry_index, entry_label, zero padding.
   input  logic [nclab_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tuser: op.
   input  logic [0:0]                         req_tuser,
   // Response stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: region_label, nearest_index, zero padding.
   output logic [nclab_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // Register port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [nclab_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [nclab_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [nclab_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int CB = nclab_pkg::COORD_BITS;
   localparam int IB = nclab_pkg::INDEX_BITS;
   localparam int LB = nclab_pkg::LABEL_BITS;
   localparam int NC = nclab_pkg::MAX_CENTROIDS;

   logic [nclab_pkg::COUNT_BITS-1:0] count_ff;
   logic [nclab_pkg::EFF_BITS-1:0]   eff_count;
   logic                             busy_ff;
   logic                             busy_in;
   logic                             done_valid_ff;
   logic                             done_valid_in;
   logic [LB-1:0]                    done_label_ff;
   logic [IB-1:0]                    done_index_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [LB-1:0]                    rsp_label_ff;
   logic [IB-1:0]                    rsp_index_ff;
   logic                             req_accept;
   logic                             load_accept;
   logic                             query_accept;
   logic                             csr_write;
   logic                             done_move;
   logic [CB-1:0]                    in_x;
   logic [CB-1:0]                    in_y;
   logic [IB-1:0]                    in_index;
   logic [LB-1:0]                    in_label;
   nclab_pkg::op_type                in_op;
   nclab_pkg::token_type             launch_tok;
   nclab_pkg::token_type             final_tok;
   nclab_pkg::token_type             chain_tok [NC+1];

   // Unpack the request beat.
   assign in_op    = nclab_pkg::op_type'(req_tuser[0]);
   assign in_x     = req_tdata[CB-1:0];
   assign in_y     = req_tdata[2*CB-1:CB];
   assign in_index = req_tdata[2*CB+IB-1:2*CB];
   assign in_label = req_tdata[2*CB+IB+LB-1:2*CB+IB];

   assign req_tready   = !busy_ff && !reset;
   assign req_accept   = req_tvalid && req_tready;
   assign load_accept  = req_accept && (in_op == nclab_pkg::OP_LOAD);
   assign query_accept = req_accept && (in_op == nclab_pkg::OP_QUERY);

   // Register port: one count register, no wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == nclab_pkg::ADDR_CENTROID_COUNT);
   assign csr_prdata = (csr_paddr == nclab_pkg::ADDR_CENTROID_COUNT)
                       ? nclab_pkg::CSR_DATA_BITS'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= nclab_pkg::COUNT_BITS'(1);
      end else if (csr_write) begin
         count_ff <= csr_pwdata[nclab_pkg::COUNT_BITS-1:0];
      end
   end

   // Number of cells searched, with zero raised to one and large counts capped.
   always_comb begin
      priority if (count_ff == '0) begin
         eff_count = nclab_pkg::EFF_BITS'(1);
      end else if (32'(count_ff) > 32'(NC)) begin
         eff_count = nclab_pkg::EFF_BITS'(NC);
      end else begin
         eff_count = nclab_pkg::EFF_BITS'(count_ff);
      end
   end

   // Token that enters the first cell when a query beat is taken.
   always_comb begin
      launch_tok            = '0;
      launch_tok.valid      = query_accept;
      launch_tok.x          = in_x;
      launch_tok.y          = in_y;
   end

   assign chain_tok[0] = launch_tok;

   // The chain of cells, one per table entry.
   for (genvar g = 0; g < NC; g++) begin : g_cell
      nclab_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (IB'(g)),
         .active_count (eff_count),
         .wr_en        (load_accept && (in_index == IB'(g))),
         .wr_x         (in_x),
         .wr_y         (in_y),
         .wr_label     (in_label),
         .tok_in       (chain_tok[g]),
         .tok_out      (chain_tok[g+1])
      );
   end

   // The last cell's distance still has to be compared.
   assign final_tok = nclab_pkg::merge_pend(chain_tok[NC]);

   // A finished result waits in the done stage until the output register frees.
   assign done_move     = done_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign done_valid_in = final_tok.valid || (done_valid_ff && !done_move);
   assign rsp_valid_in  = done_move || (rsp_valid_ff && !rsp_tready);
   assign busy_in       = query_accept || (busy_ff && !done_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         done_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (final_tok.valid) begin
         done_label_ff <= final_tok.best_label;
         done_index_ff <= final_tok.best_index;
      end
      if (done_move) begin
         rsp_label_ff <= done_label_ff;
         rsp_index_ff <= done_index_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = nclab_pkg::RSP_DATA_BITS'({rsp_index_ff, rsp_label_ff});

endmodule
